@@ rtl/multichannel_boxcar_average_scaler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the boxcar average scaler
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BOXCAR_AVERAGE_SCALER_UNIT_MACROS_SVH
`define MULTICHANNEL_BOXCAR_AVERAGE_SCALER_UNIT_MACROS_SVH

// clocked property, muted while reset is high
`define MBAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked across reset
`define MBAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mbas_pkg.sv @@
// ----------------------------------------------------------------------------
// mbas_pkg
// Widths, scaling constants and lane control type for the boxcar scaler.
// ----------------------------------------------------------------------------
package mbas_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int LEVEL_W      = 8;
   localparam int CHANNELS_DEF = 5;
   localparam int WINDOW_DEF   = 20;

   localparam int FULL_SCALE  = 4095;
   localparam int LEVEL_SCALE = 255;

   // level = floor(avg*255/4095) = (avg * LEVEL_MUL) >> LEVEL_SHIFT, exact for avg < 2^12
   localparam int LEVEL_SHIFT = 32;
   localparam logic [63:0] LEVEL_RECIP =
      ((64'd1 << LEVEL_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   localparam logic [63:0] LEVEL_MUL_FULL = LEVEL_RECIP * 64'(LEVEL_SCALE);
   localparam int LEVEL_MUL_W = $clog2(LEVEL_MUL_FULL + 64'd1);
   localparam logic [LEVEL_MUL_W-1:0] LEVEL_MUL = LEVEL_MUL_FULL[LEVEL_MUL_W-1:0];

   // per-item strobes from the control pipe to every lane
   typedef struct packed {
      logic accept;      // item taken: write ring, fetch the slot's old sample
      logic wrapped_s1;  // item in stage 1 replaces a real old sample
      logic adv_s2;      // stage 1 item moves into the running sum
      logic adv_s3;      // stage 2 item moves into the divide product
   } lane_ctl_type;

endpackage

@@ rtl/mbas_ram.sv @@
// ----------------------------------------------------------------------------
// mbas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbas_ram #(
   parameter int WIDTH  = 12,
   parameter int DEPTH  = 20,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the value held before a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mbas_lane.sv @@
// ----------------------------------------------------------------------------
// mbas_lane
// One channel: sample ring, running window sum, divide by the window and
// scale to an 8-bit level.
// ----------------------------------------------------------------------------
module mbas_lane
   import mbas_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctl_type               ctl,
   input  logic [$clog2(WINDOW)-1:0]  slot,
   input  logic [SAMPLE_W-1:0]        sample,
   output logic [LEVEL_W-1:0]         level
);

   localparam int ADDR_W    = $clog2(WINDOW);
   localparam int SUM_W     = SAMPLE_W + ADDR_W;
   // floor(sum/WINDOW) = (sum * AVG_RECIP) >> AVG_SHIFT, exact for sum < 2^SUM_W
   localparam int AVG_SHIFT = SUM_W + ADDR_W;
   localparam int RECIP_W   = SUM_W + 1;
   localparam logic [63:0] AVG_RECIP_FULL =
      ((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] AVG_RECIP = AVG_RECIP_FULL[RECIP_W-1:0];
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int SCALED_W  = SAMPLE_W + LEVEL_MUL_W;

   logic [SAMPLE_W-1:0] old_sample;
   logic [SAMPLE_W-1:0] sample_s1_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    old_term;
   logic [PROD_W-1:0]   prod_ff;
   logic [SAMPLE_W-1:0] avg;
   logic [SCALED_W-1:0] scaled;

   // ring: write the new sample and fetch the one it replaces
   mbas_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW),
      .ADDR_W(ADDR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ctl.accept),
      .wr_addr(slot),
      .wr_data(sample),
      .rd_en  (ctl.accept),
      .rd_addr(slot),
      .rd_data(old_sample)
   );

   // stage 1: new sample beside the fetched old one
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         sample_s1_ff <= sample;
      end
   end

   // stage 2: running sum, the old sample counts only once the ring is full
   assign old_term = ctl.wrapped_s1 ? SUM_W'(old_sample) : '0;
   assign sum_in   = sum_ff + SUM_W'(sample_s1_ff) - old_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.adv_s2) begin
         sum_ff <= sum_in;
      end
   end

   // stage 3: divide by the window through the reciprocal product
   always_ff @(posedge clock) begin
      if (ctl.adv_s3) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);
      end
   end

   // scale to eight bits; registered in the merge stage
   assign avg    = prod_ff[AVG_SHIFT +: SAMPLE_W];
   assign scaled = SCALED_W'(avg) * SCALED_W'(LEVEL_MUL);
   assign level  = scaled[LEVEL_SHIFT +: LEVEL_W];

endmodule

@@ rtl/mbas_merge.sv @@
// ----------------------------------------------------------------------------
// mbas_merge
// Output register: gathers the lane levels and the window flag into one
// result item and holds it until taken.
// ----------------------------------------------------------------------------
module mbas_merge
   import mbas_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_s3,
   input  logic                              full_s3,
   input  logic [CHANNELS-1:0][LEVEL_W-1:0]  lane_level,
   output logic                              out_load,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [CHANNELS*LEVEL_W-1:0]       rsp_tdata,
   output logic [0:0]                        rsp_tuser
);

   logic                             valid_ff;
   logic                             full_ff;
   logic [CHANNELS-1:0][LEVEL_W-1:0] levels_ff;

   // output register may load when empty or being drained
   assign out_load = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_load) begin
         valid_ff <= valid_s3;
      end
   end

   // levels stay zero until the ring has wrapped
   always_ff @(posedge clock) begin
      if (out_load && valid_s3) begin
         full_ff   <= full_s3;
         levels_ff <= full_s3 ? lane_level : '0;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = levels_ff;
   assign rsp_tuser[0] = full_ff;

endmodule

@@ rtl/multichannel_boxcar_average_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_boxcar_average_scaler_unit
// Moving-average (boxcar) filter over CHANNELS converter channels with
// 8-bit scaled outputs.
// ----------------------------------------------------------------------------
// Each item carries one 12-bit sample per channel and yields one result
// item. Every channel keeps its last WINDOW samples in a small RAM and a
// running sum (new sample in, replaced sample out), so the block takes one
// item per clock with no gaps while rsp_tready keeps the output drained;
// each result passes the RAM fetch at the accepting edge, then sum,
// reciprocal divide, and scale into the output register. Levels are
// floor(floor(sum/WINDOW)*255/4095) and read zero,
// with rsp_tuser low, for the first WINDOW items; from item WINDOW+1 on
// rsp_tuser is high and the levels track the window. Each stage stalls
// only when the stage after it is full, so input keeps flowing while a
// result waits in the output register until the earlier stages fill. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multichannel_boxcar_average_scaler_unit
   import mbas_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int WINDOW   = WINDOW_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // req_tdata: chan0_sample .. chan{CHANNELS-1}_sample, 12 bits each, zero pad
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((CHANNELS*SAMPLE_W+7)/8)*8-1:0]         req_tdata,
   // rsp_tdata: chan0_level .. chan{CHANNELS-1}_level, 8 bits each
   // rsp_tuser: window_full
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [CHANNELS*LEVEL_W-1:0]                   rsp_tdata,
   output logic [0:0]                                    rsp_tuser
);

   localparam int ADDR_W = $clog2(WINDOW);

   logic                             accept;
   logic                             load_s1, load_s2, load_s3, out_load;
   logic                             valid_s1_ff, valid_s2_ff, valid_s3_ff;
   logic                             full_s1_ff, full_s2_ff, full_s3_ff;
   logic [ADDR_W-1:0]                slot_ff;
   logic                             wrapped_ff;
   lane_ctl_type                     lane_ctl;
   logic [CHANNELS-1:0][LEVEL_W-1:0] lane_level;

   // stall chain: a stage loads when empty or when the next one loads
   assign load_s3    = !valid_s3_ff || out_load;
   assign load_s2    = !valid_s2_ff || load_s3;
   assign load_s1    = !valid_s1_ff || load_s2;
   assign req_tready = load_s1;
   assign accept     = req_tvalid && load_s1;

   // ring write slot and wrap flag
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
      end else if (accept) begin
         if (slot_ff == ADDR_W'(WINDOW - 1)) begin
            slot_ff    <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + ADDR_W'(1);
         end
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
      end else begin
         if (load_s1) begin
            valid_s1_ff <= accept;
         end
         if (load_s2) begin
            valid_s2_ff <= valid_s1_ff;
         end
         if (load_s3) begin
            valid_s3_ff <= valid_s2_ff;
         end
      end
   end

   // window-full flag travels with its item
   always_ff @(posedge clock) begin
      if (accept) begin
         full_s1_ff <= wrapped_ff;
      end
      if (load_s2 && valid_s1_ff) begin
         full_s2_ff <= full_s1_ff;
      end
      if (load_s3 && valid_s2_ff) begin
         full_s3_ff <= full_s2_ff;
      end
   end

   assign lane_ctl.accept     = accept;
   assign lane_ctl.wrapped_s1 = full_s1_ff;
   assign lane_ctl.adv_s2     = load_s2 && valid_s1_ff;
   assign lane_ctl.adv_s3     = load_s3 && valid_s2_ff;

   // one lane per channel
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      mbas_lane #(
         .WINDOW(WINDOW)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .slot  (slot_ff),
         .sample(req_tdata[c*SAMPLE_W +: SAMPLE_W]),
         .level (lane_level[c])
      );
   end

   // merge lane levels into the result item
   mbas_merge #(
      .CHANNELS(CHANNELS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .valid_s3  (valid_s3_ff),
      .full_s3   (full_s3_ff),
      .lane_level(lane_level),
      .out_load  (out_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ rtl/mbas_checker.sv @@
// ----------------------------------------------------------------------------
// mbas_checker
// Port-level checks on the boxcar scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_boxcar_average_scaler_unit_macros.svh"

module mbas_checker
   import mbas_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [CHANNELS*LEVEL_W-1:0]       rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   logic seen_full_ff;

   // set once a full-window item has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tuser[0]) begin
         seen_full_ff <= 1'b1;
      end
   end

   // a waiting item holds its payload
   `MBAS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp item changed while stalled")

   // levels read zero until the window is full
   `MBAS_ASSERT(a_zero_before_full, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0, "nonzero level before window full")

   // once full, every later item is full
   `MBAS_ASSERT(a_full_sticky, clock, reset, rsp_tvalid && seen_full_ff |-> rsp_tuser[0], "window_full dropped")

   // an empty output register never blocks the input
   `MBAS_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "input stalled with empty output")

endmodule

bind multichannel_boxcar_average_scaler_unit mbas_checker #(
   .CHANNELS(CHANNELS)
) u_mbas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
